@@ rtl/sexl_pkg.sv @@
package sexl_pkg;

    localparam int DEF_LINE_WIDTH   = 16;
    localparam int DEF_COLUMN_WIDTH = 16;

    // queue depths, kept at powers of two so the pointers wrap on their own
    localparam int Q_DEPTH = 4;
    localparam int R_DEPTH = 4;

    localparam int NUM_KW = 7;

    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    localparam logic [2:0] KW_NONE = 3'd0;

    typedef enum logic [2:0] {
        CL_OTHER,
        CL_LPAREN,
        CL_RPAREN,
        CL_QUOTE,
        CL_SPACE,
        CL_NEWLINE
    } char_class_t;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_SYM,
        MODE_STR
    } lex_mode_t;

    typedef enum logic [2:0] {
        TK_LPAREN  = 3'd0,
        TK_RPAREN  = 3'd1,
        TK_STRING  = 3'd2,
        TK_SYMBOL  = 3'd3,
        TK_KEYWORD = 3'd4
    } token_kind_t;

    typedef struct packed {
        char_class_t cls;
        logic [7:0]  ch;
        logic        eos;
    } entry_t;

    typedef struct packed {
        token_kind_t kind;
        logic [2:0]  kw;
        logic [15:0] line;
        logic [15:0] start_col;
        logic [15:0] end_col;
        logic [15:0] len;
        logic        unterm;
        logic        last;
    } result_t;

    localparam logic [15:0] KW_LEN [NUM_KW] = '{16'd5, 16'd4, 16'd2, 16'd3, 16'd3, 16'd4, 16'd4};

    localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
        '{"q", "u", "o", "t", "e", 8'h00, 8'h00, 8'h00},
        '{"a", "t", "o", "m", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "q", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"c", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"c", "d", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"c", "o", "n", "s", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"c", "o", "n", "d", 8'h00, 8'h00, 8'h00, 8'h00}
    };

    // keywords that still agree with byte c at position pos
    function automatic logic [NUM_KW-1:0] kw_hits(input logic [7:0] c, input logic [15:0] pos);
        logic [NUM_KW-1:0] hits;
        hits = '0;
        for (int k = 0; k < NUM_KW; k++)
        begin
            hits[k] = (pos < KW_LEN[k]) && (KW_TEXT[k][pos[2:0]] == c);
        end
        return hits;
    endfunction

    function automatic logic [2:0] kw_code(input logic [NUM_KW-1:0] mask, input logic [15:0] len);
        logic [2:0] code;
        code = KW_NONE;
        for (int k = 0; k < NUM_KW; k++)
        begin
            if (mask[k] && (len == KW_LEN[k]))
            begin
                code = 3'(k + 1);
            end
        end
        return code;
    endfunction

endpackage

@@ rtl/sexpr_token_lexer_core.sv @@
// s-expression token lexer
// the input stream carries one source byte per transaction; tlast marks the
// final byte of a source, after which a pending symbol or string is flushed
// and the line and column counters go back to one
// the output stream carries one token per transaction: kind in tuser, the
// keyword code, line, start and end columns, length and the unterminated
// flag in tdata; tlast marks the last token caused by one input byte
// throughput: one byte per cycle while the token queue has room; a paren that
// ends a symbol gives two tokens, which leave one output transaction per cycle
// path: the edge that takes a byte writes it into the 4-entry byte queue, and
// a later lexer step writes the tokens it causes into the 4-entry token queue,
// whose head entry drives the output
// when the receiver stalls, tokens collect in the token queue, the lexer
// holds once fewer than two slots are free, then the byte queue fills and
// tready drops
// reset empties both queues, sets the lexer idle and line and column to one
module sexpr_token_lexer_core #(
    parameter int LINE_WIDTH   = sexl_pkg::DEF_LINE_WIDTH,
    parameter int COLUMN_WIDTH = sexl_pkg::DEF_COLUMN_WIDTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // ch
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // keyword_code, start_line, start_column, end_column,
                                        // text_length, unterminated, zero pad
    output logic [2:0]  m_axis_tuser,   // token_kind
    output logic        m_axis_tlast
);

    logic              q_valid;
    logic              q_pop;
    sexl_pkg::entry_t  q_entry;
    sexl_pkg::result_t res;

    sexl_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_valid       (q_valid),
        .q_entry       (q_entry),
        .q_pop         (q_pop)
    );

    sexl_back #(
        .LINE_WIDTH   (LINE_WIDTH),
        .COLUMN_WIDTH (COLUMN_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res_data  (res)
    );

    assign m_axis_tdata = {4'b0, res.unterm, res.len, res.end_col, res.start_col,
                           res.line, res.kw};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;

endmodule

@@ rtl/sexl_front.sv @@
module sexl_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,
    input  logic                s_axis_tlast,
    output logic                q_valid,
    output sexl_pkg::entry_t    q_entry,
    input  logic                q_pop
);

    localparam int AW = $clog2(sexl_pkg::Q_DEPTH);
    localparam int CW = $clog2(sexl_pkg::Q_DEPTH + 1);

    sexl_pkg::entry_t      q_mem_reg [sexl_pkg::Q_DEPTH];
    logic [AW-1:0]         wr_reg, wr_next;
    logic [AW-1:0]         rd_reg, rd_next;
    logic [CW-1:0]         count_reg, count_next;
    sexl_pkg::char_class_t cls;
    logic                  push;

    always_comb
    begin
        unique case (s_axis_tdata)
            sexl_pkg::CH_LPAREN:  cls = sexl_pkg::CL_LPAREN;
            sexl_pkg::CH_RPAREN:  cls = sexl_pkg::CL_RPAREN;
            sexl_pkg::CH_QUOTE:   cls = sexl_pkg::CL_QUOTE;
            sexl_pkg::CH_SPACE,
            sexl_pkg::CH_TAB:     cls = sexl_pkg::CL_SPACE;
            sexl_pkg::CH_NEWLINE: cls = sexl_pkg::CL_NEWLINE;
            default:              cls = sexl_pkg::CL_OTHER;
        endcase
    end

    assign s_axis_tready = (count_reg != CW'(sexl_pkg::Q_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign q_valid       = (count_reg != '0);
    assign q_entry       = q_mem_reg[rd_reg];

    always_comb
    begin
        wr_next    = push ? wr_reg + AW'(1) : wr_reg;
        rd_next    = q_pop ? rd_reg + AW'(1) : rd_reg;
        count_next = count_reg + CW'(push) - CW'(q_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_reg] <= '{cls: cls, ch: s_axis_tdata, eos: s_axis_tlast};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

endmodule

@@ rtl/sexl_back.sv @@
module sexl_back #(
    parameter int LINE_WIDTH   = sexl_pkg::DEF_LINE_WIDTH,
    parameter int COLUMN_WIDTH = sexl_pkg::DEF_COLUMN_WIDTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  sexl_pkg::entry_t    q_entry,
    output logic                q_pop,
    output logic                res_valid,
    input  logic                res_ready,
    output sexl_pkg::result_t   res_data
);

    localparam int MW0 = (LINE_WIDTH > COLUMN_WIDTH) ? LINE_WIDTH : COLUMN_WIDTH;
    localparam int WW  = ((MW0 > 16) ? MW0 : 16) + 2;
    localparam int RAW = $clog2(sexl_pkg::R_DEPTH);
    localparam int RCW = $clog2(sexl_pkg::R_DEPTH + 1);
    localparam logic [WW-1:0] CMAX = WW'({COLUMN_WIDTH{1'b1}});

    function automatic logic [COLUMN_WIDTH-1:0] col_clamp(input logic [WW-1:0] v);
        return (v > CMAX) ? {COLUMN_WIDTH{1'b1}} : v[COLUMN_WIDTH-1:0];
    endfunction

    function automatic logic [15:0] clip16(input logic [WW-1:0] v);
        return (v > WW'(16'hFFFF)) ? 16'hFFFF : v[15:0];
    endfunction

    sexl_pkg::lex_mode_t       mode_reg, mode_next, mode_mid;
    logic [LINE_WIDTH-1:0]     line_reg, line_next, line_mid, line_inc;
    logic [COLUMN_WIDTH-1:0]   col_reg, col_next, col_mid, col_a, col_a_inc;
    logic [COLUMN_WIDTH-1:0]   start_reg, start_next, start_mid;
    logic [15:0]               len_reg, len_next, len_mid, len_inc;
    logic [6:0]                kwm_reg, kwm_next, kwm_mid;

    logic [COLUMN_WIDTH-1:0]   ec_sym_end, ec_str_end, ec_sym_mid, ec_str_mid;
    logic [2:0]                code_end, code_mid;
    logic                      in_str, in_sym, is_par, is_brk;
    logic                      str_close, sym_end, sym_cont, idle_path;
    logic                      paren_emit, sym_open, str_open, eos_sym, eos_str;
    sexl_pkg::result_t         r0, r1, paren_res;
    logic [1:0]                n_res;

    sexl_pkg::result_t         r_mem_reg [sexl_pkg::R_DEPTH];
    logic [RAW-1:0]            r_wr_reg, r_wr_next, r_rd_reg, r_rd_next;
    logic [RCW-1:0]            r_count_reg, r_count_next;
    logic                      out_pop;

    assign q_pop     = q_valid && (r_count_reg <= RCW'(sexl_pkg::R_DEPTH - 2));
    assign res_valid = (r_count_reg != '0);
    assign res_data  = r_mem_reg[r_rd_reg];
    assign out_pop   = res_valid && res_ready;

    // byte decode against the current mode
    assign in_str     = (mode_reg == sexl_pkg::MODE_STR);
    assign in_sym     = (mode_reg == sexl_pkg::MODE_SYM);
    assign is_par     = (q_entry.cls == sexl_pkg::CL_LPAREN) || (q_entry.cls == sexl_pkg::CL_RPAREN);
    assign is_brk     = is_par || (q_entry.cls == sexl_pkg::CL_SPACE)
                        || (q_entry.cls == sexl_pkg::CL_NEWLINE);
    assign str_close  = in_str && (q_entry.cls == sexl_pkg::CL_QUOTE);
    assign sym_end    = in_sym && is_brk;
    assign sym_cont   = in_sym && !is_brk;
    assign idle_path  = !in_str && !sym_cont;
    assign paren_emit = idle_path && is_par;
    assign sym_open   = idle_path && (q_entry.cls == sexl_pkg::CL_OTHER);
    assign str_open   = idle_path && (q_entry.cls == sexl_pkg::CL_QUOTE);

    // next state
    always_comb
    begin
        unique case (mode_reg)
            sexl_pkg::MODE_STR: mode_mid = str_close ? sexl_pkg::MODE_IDLE : sexl_pkg::MODE_STR;
            sexl_pkg::MODE_SYM: mode_mid = sym_cont ? sexl_pkg::MODE_SYM : sexl_pkg::MODE_IDLE;
            default:
            begin
                if (str_open)
                begin
                    mode_mid = sexl_pkg::MODE_STR;
                end
                else if (sym_open)
                begin
                    mode_mid = sexl_pkg::MODE_SYM;
                end
                else
                begin
                    mode_mid = sexl_pkg::MODE_IDLE;
                end
            end
        endcase
        if (!q_pop)
        begin
            mode_next = mode_reg;
        end
        else if (q_entry.eos)
        begin
            mode_next = sexl_pkg::MODE_IDLE;
        end
        else
        begin
            mode_next = mode_mid;
        end
    end

    // counters and results
    always_comb
    begin
        len_inc    = (len_reg == 16'hFFFF) ? len_reg : len_reg + 16'd1;
        line_inc   = (line_reg == '1) ? line_reg : line_reg + LINE_WIDTH'(1);
        ec_sym_end = col_clamp(WW'(start_reg) + WW'(len_reg));
        ec_str_end = col_clamp(WW'(start_reg) + WW'(len_reg) + WW'(2));
        code_end   = sexl_pkg::kw_code(kwm_reg, len_reg);
        col_a      = sym_end ? ec_sym_end : col_reg;
        col_a_inc  = (col_a == '1) ? col_a : col_a + COLUMN_WIDTH'(1);

        line_mid = (idle_path && (q_entry.cls == sexl_pkg::CL_NEWLINE)) ? line_inc : line_reg;

        if (str_close)
        begin
            col_mid = ec_str_end;
        end
        else if (!idle_path)
        begin
            col_mid = col_reg;
        end
        else if (is_par || (q_entry.cls == sexl_pkg::CL_SPACE))
        begin
            col_mid = col_a_inc;
        end
        else if (q_entry.cls == sexl_pkg::CL_NEWLINE)
        begin
            col_mid = COLUMN_WIDTH'(1);
        end
        else
        begin
            col_mid = col_a;
        end

        start_mid = (sym_open || str_open) ? col_reg : start_reg;

        if (sym_open)
        begin
            len_mid = 16'd1;
            kwm_mid = sexl_pkg::kw_hits(q_entry.ch, 16'd0);
        end
        else if (sym_cont)
        begin
            len_mid = len_inc;
            kwm_mid = kwm_reg & sexl_pkg::kw_hits(q_entry.ch, len_reg);
        end
        else if (str_open)
        begin
            len_mid = 16'd0;
            kwm_mid = kwm_reg;
        end
        else if (in_str && !str_close)
        begin
            len_mid = len_inc;
            kwm_mid = kwm_reg;
        end
        else
        begin
            len_mid = len_reg;
            kwm_mid = kwm_reg;
        end

        eos_sym    = q_entry.eos && (mode_mid == sexl_pkg::MODE_SYM);
        eos_str    = q_entry.eos && (mode_mid == sexl_pkg::MODE_STR);
        ec_sym_mid = col_clamp(WW'(start_mid) + WW'(len_mid));
        ec_str_mid = col_clamp(WW'(start_mid) + WW'(len_mid) + WW'(2));
        code_mid   = sexl_pkg::kw_code(kwm_mid, len_mid);

        paren_res.kind      = (q_entry.cls == sexl_pkg::CL_LPAREN) ? sexl_pkg::TK_LPAREN
                                                                   : sexl_pkg::TK_RPAREN;
        paren_res.kw        = sexl_pkg::KW_NONE;
        paren_res.line      = clip16(WW'(line_reg));
        paren_res.start_col = clip16(WW'(col_a));
        paren_res.end_col   = clip16(WW'(col_a_inc));
        paren_res.len       = 16'd1;
        paren_res.unterm    = 1'b0;
        paren_res.last      = 1'b1;

        r0.line   = clip16(WW'(line_reg));
        r0.unterm = 1'b0;
        r0.last   = 1'b1;
        if (str_close)
        begin
            r0.kind      = sexl_pkg::TK_STRING;
            r0.kw        = sexl_pkg::KW_NONE;
            r0.start_col = clip16(WW'(start_reg));
            r0.end_col   = clip16(WW'(ec_str_end));
            r0.len       = len_reg;
        end
        else if (sym_end)
        begin
            r0.kind      = (code_end != sexl_pkg::KW_NONE) ? sexl_pkg::TK_KEYWORD
                                                           : sexl_pkg::TK_SYMBOL;
            r0.kw        = code_end;
            r0.start_col = clip16(WW'(start_reg));
            r0.end_col   = clip16(WW'(ec_sym_end));
            r0.len       = len_reg;
            r0.last      = !paren_emit;
        end
        else if (paren_emit)
        begin
            r0 = paren_res;
        end
        else if (eos_sym)
        begin
            r0.kind      = (code_mid != sexl_pkg::KW_NONE) ? sexl_pkg::TK_KEYWORD
                                                           : sexl_pkg::TK_SYMBOL;
            r0.kw        = code_mid;
            r0.start_col = clip16(WW'(start_mid));
            r0.end_col   = clip16(WW'(ec_sym_mid));
            r0.len       = len_mid;
        end
        else
        begin
            r0.kind      = sexl_pkg::TK_STRING;
            r0.kw        = sexl_pkg::KW_NONE;
            r0.start_col = clip16(WW'(start_mid));
            r0.end_col   = clip16(WW'(ec_str_mid));
            r0.len       = len_mid;
            r0.unterm    = 1'b1;
        end
        r1 = paren_res;

        if (!q_pop)
        begin
            n_res = 2'd0;
        end
        else if (sym_end && paren_emit)
        begin
            n_res = 2'd2;
        end
        else if (str_close || sym_end || paren_emit || eos_sym || eos_str)
        begin
            n_res = 2'd1;
        end
        else
        begin
            n_res = 2'd0;
        end

        if (q_pop)
        begin
            line_next  = q_entry.eos ? LINE_WIDTH'(1) : line_mid;
            col_next   = q_entry.eos ? COLUMN_WIDTH'(1) : col_mid;
            len_next   = q_entry.eos ? 16'd0 : len_mid;
            start_next = start_mid;
            kwm_next   = kwm_mid;
        end
        else
        begin
            line_next  = line_reg;
            col_next   = col_reg;
            len_next   = len_reg;
            start_next = start_reg;
            kwm_next   = kwm_reg;
        end

        r_wr_next    = r_wr_reg + RAW'(n_res);
        r_rd_next    = out_pop ? r_rd_reg + RAW'(1) : r_rd_reg;
        r_count_next = r_count_reg + RCW'(n_res) - RCW'(out_pop);
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        kwm_reg   <= kwm_next;
        if (n_res != 2'd0)
        begin
            r_mem_reg[r_wr_reg] <= r0;
        end
        if (n_res == 2'd2)
        begin
            r_mem_reg[r_wr_reg + RAW'(1)] <= r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= sexl_pkg::MODE_IDLE;
            line_reg    <= LINE_WIDTH'(1);
            col_reg     <= COLUMN_WIDTH'(1);
            len_reg     <= '0;
            r_wr_reg    <= '0;
            r_rd_reg    <= '0;
            r_count_reg <= '0;
        end
        else
        begin
            mode_reg    <= mode_next;
            line_reg    <= line_next;
            col_reg     <= col_next;
            len_reg     <= len_next;
            r_wr_reg    <= r_wr_next;
            r_rd_reg    <= r_rd_next;
            r_count_reg <= r_count_next;
        end
    end

endmodule

@@ rtl/sexl_checker.sv @@
module sexl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // stalled token holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("token changed while stalled");

    // parens are one character, never keywords, never unterminated
    a_paren_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == sexl_pkg::TK_LPAREN || m_axis_tuser == sexl_pkg::TK_RPAREN)
            |-> m_axis_tdata[66:51] == 16'd1 && m_axis_tdata[2:0] == sexl_pkg::KW_NONE
                && !m_axis_tdata[67])
        else $error("malformed paren token");

    // keyword code present exactly on keyword tokens
    a_kw_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((m_axis_tuser == sexl_pkg::TK_KEYWORD)
            == (m_axis_tdata[2:0] != sexl_pkg::KW_NONE)))
        else $error("keyword code and kind disagree");

    // an unterminated string only comes from the final byte, as its only token
    a_unterm: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[67] |-> m_axis_tuser == sexl_pkg::TK_STRING && m_axis_tlast)
        else $error("unterminated flag on a non-string token");

endmodule

bind sexpr_token_lexer_core sexl_checker u_sexl_checker (.*);
